### rtl/core/dik_pkg.sv
// types, sizes and constants shared by the delta inverse kinematics pipeline
// no dependencies; used by dik_cordic, dik_arm and delta_inverse_kinematics
package dik_pkg;

    localparam int IN_W         = 19;
    localparam int REG_W        = 18;
    localparam int CFG_IDX_W    = 2;
    localparam int OFF_W        = 19;
    localparam int COEF_W       = 32;
    localparam int PROD_W       = IN_W + COEF_W;
    localparam int XO_W         = 21;
    localparam int SQ_W         = 42;
    localparam int NUM_W        = SQ_W + 1;
    localparam int Q_W          = 21;
    localparam int K_W          = Q_W + 1;
    localparam int CIN_W        = 23;
    localparam int CX_W         = 34;
    localparam int ANG_W        = 35;
    localparam int SH_W         = 5;
    localparam int NORM_TOP     = 29;
    localparam int DIV_STEPS    = Q_W;
    localparam int SQRT_STEPS   = 21;
    localparam int CORDIC_STEPS = 28;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam int ARM_LAT      = 5 + DIV_STEPS + 2 + SQRT_STEPS + CORDIC_LAT + 2;
    localparam int NUM_ARMS     = 3;
    localparam int TDATA_W      = 80;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_RADIUS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EFFECTOR_RADIUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LENGTH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LENGTH    = 2'd3;

    localparam logic [REG_W-1:0] BASE_RADIUS_RST     = 18'd6554;
    localparam logic [REG_W-1:0] EFFECTOR_RADIUS_RST = 18'd3277;
    localparam logic [REG_W-1:0] UPPER_LENGTH_RST    = 18'd13107;
    localparam logic [REG_W-1:0] LOWER_LENGTH_RST    = 18'd26214;

    // arm frame rotation, Q30
    localparam logic signed [COEF_W-1:0] ROT_COS [NUM_ARMS] =
        '{32'sd1073741824, -32'sd536870912, -32'sd536870912};
    localparam logic signed [COEF_W-1:0] ROT_SIN [NUM_ARMS] =
        '{32'sd0, 32'sd929887697, -32'sd929887697};

    localparam logic signed [ANG_W-1:0] Q30_PI      = 35'sd3373259426;
    localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 35'sd1686629713;
    localparam logic signed [ANG_W-1:0] Q30_TWO_PI  = 35'sd6746518852;

    localparam logic signed [ANG_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        35'sd843314856, 35'sd497837829, 35'sd263043836, 35'sd133525158,
        35'sd67021686, 35'sd33543515, 35'sd16775850, 35'sd8388437,
        35'sd4194282, 35'sd2097149, 35'sd1048575, 35'sd524287,
        35'sd262143, 35'sd131071, 35'sd65535, 35'sd32767,
        35'sd16383, 35'sd8191, 35'sd4095, 35'sd2047,
        35'sd1023, 35'sd511, 35'sd255, 35'sd127,
        35'sd63, 35'sd31, 35'sd15, 35'sd8
    };

    typedef struct packed {
        logic signed [OFF_W-1:0] off;
        logic [REG_W-1:0]        l1;
        logic [REG_W-1:0]        l2;
    } dik_cfg_t;

endpackage

### rtl/core/delta_inverse_kinematics.sv
// delta robot inverse kinematics, top level: config registers, three arm pipelines, output stage
// depends on dik_pkg, dik_arm, dik_cordic
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  pos_x, pos_y, pos_z, tool_rotation
//  m_*       out  m_tvalid/m_tready  arm_angle_a/b/c, tool_angle, unreachable (tuser)
//  cfg_*     in   cfg_wr_en          cfg_index selects register, cfg_wdata value
//
// one request per cycle; the pipeline depth is set by the 21 divider stages,
// 21 square root stages and 30 atan2 stages in each arm
// all stages advance together; when the output holds a result that is not taken the
// whole pipeline and s_tready stall, nothing is dropped or repeated
// reset clears valid bits and loads default geometry
module delta_inverse_kinematics #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // pos_x, pos_y, pos_z, tool_rotation, zero pad
    input  logic [dik_pkg::TDATA_W-1:0]     s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // arm_angle_a, arm_angle_b, arm_angle_c, tool_angle, zero pad
    output logic [dik_pkg::TDATA_W-1:0]     m_tdata,
    // unreachable
    output logic [0:0]                      m_tuser,
    input  logic                            cfg_wr_en,
    input  logic [dik_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dik_pkg::REG_W-1:0]       cfg_wdata
);
    import dik_pkg::*;

    localparam int TOTAL_LAT = ARM_LAT + 1;

    logic [REG_W-1:0]       base_radius_reg;
    logic [REG_W-1:0]       effector_radius_reg;
    logic [REG_W-1:0]       upper_length_reg;
    logic [REG_W-1:0]       lower_length_reg;
    dik_cfg_t               cfg;
    logic                   en;
    logic                   vld_reg [TOTAL_LAT];
    logic signed [IN_W-1:0] pos_x, pos_y, pos_z;
    logic [IN_W-1:0]        tool_reg [ARM_LAT];
    logic signed [IN_W-1:0] arm_ang [NUM_ARMS];
    logic [NUM_ARMS-1:0]    arm_bad;
    logic signed [IN_W-1:0] ang_out_reg [NUM_ARMS];
    logic [IN_W-1:0]        tool_out_reg;
    logic                   unr_reg;
    logic                   reach;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_radius_reg     <= BASE_RADIUS_RST;
            effector_radius_reg <= EFFECTOR_RADIUS_RST;
            upper_length_reg    <= UPPER_LENGTH_RST;
            lower_length_reg    <= LOWER_LENGTH_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_BASE_RADIUS:     base_radius_reg     <= cfg_wdata;
                CFG_EFFECTOR_RADIUS: effector_radius_reg <= cfg_wdata;
                CFG_UPPER_LENGTH:    upper_length_reg    <= cfg_wdata;
                CFG_LOWER_LENGTH:    lower_length_reg    <= cfg_wdata;
                default:             base_radius_reg     <= base_radius_reg;
            endcase
        end
    end

    always_comb
    begin
        cfg.off = $signed({1'b0, effector_radius_reg}) - $signed({1'b0, base_radius_reg});
        cfg.l1  = upper_length_reg;
        cfg.l2  = lower_length_reg;
    end

    assign en       = !(vld_reg[TOTAL_LAT-1] && !m_tready);
    assign s_tready = en;

    assign pos_x = s_tdata[IN_W-1:0];
    assign pos_y = s_tdata[2*IN_W-1:IN_W];
    assign pos_z = s_tdata[3*IN_W-1:2*IN_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOTAL_LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < TOTAL_LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    for (genvar a = 0; a < NUM_ARMS; a++)
    begin : g_arm
        dik_arm #(
            .FRAC_BITS (FRAC_BITS)
        ) u_arm (
            .clk     (clk),
            .en      (en),
            .cfg     (cfg),
            .rot_cos (ROT_COS[a]),
            .rot_sin (ROT_SIN[a]),
            .px      (pos_x),
            .py      (pos_y),
            .pz      (pos_z),
            .angle   (arm_ang[a]),
            .bad     (arm_bad[a])
        );
    end

    assign reach = (arm_bad == '0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tool_reg[0] <= s_tdata[4*IN_W-1:3*IN_W];
            for (int i = 1; i < ARM_LAT; i++)
                tool_reg[i] <= tool_reg[i-1];
            for (int a = 0; a < NUM_ARMS; a++)
                ang_out_reg[a] <= reach ? arm_ang[a] : '0;
            tool_out_reg <= tool_reg[ARM_LAT-1];
            unr_reg      <= !reach;
        end
    end

    assign m_tvalid   = vld_reg[TOTAL_LAT-1];
    assign m_tdata    = {(TDATA_W - 4*IN_W)'(0), tool_out_reg,
                         ang_out_reg[2], ang_out_reg[1], ang_out_reg[0]};
    assign m_tuser[0] = unr_reg;

`ifndef SYNTHESIS
    // an unreachable point reports all arm angles as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[3*IN_W-1:0] == '0)
        else $error("unreachable result with nonzero arm angles");

    // a result that is not taken stays in place with its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // an empty output stage never blocks new requests
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // a request taken while stalled output frees must enter the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted request lost at pipeline entry");
`endif

endmodule

### rtl/core/dik_cordic.sv
// pipelined atan2 in Q30 radians: normalize, quadrant fold, one cordic step per stage
// depends on dik_pkg
module dik_cordic (
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [dik_pkg::CIN_W-1:0] y_in,
    input  logic signed [dik_pkg::CIN_W-1:0] x_in,
    output logic signed [dik_pkg::ANG_W-1:0] angle
);
    import dik_pkg::*;

    logic [CIN_W-1:0]        ax;
    logic [CIN_W-1:0]        ay;
    logic [CIN_W-1:0]        mx;
    logic [SH_W-1:0]         msb;
    logic signed [CIN_W-1:0] ny_reg;
    logic signed [CIN_W-1:0] nx_reg;
    logic [SH_W-1:0]         sh_reg;
    logic                    zero_reg;
    logic signed [CX_W-1:0]  xs;
    logic signed [CX_W-1:0]  ys;
    logic signed [CX_W-1:0]  x0_next;
    logic signed [CX_W-1:0]  y0_next;
    logic signed [ANG_W-1:0] a0_next;
    logic signed [CX_W-1:0]  x_reg [CORDIC_STEPS+1];
    logic signed [CX_W-1:0]  y_reg [CORDIC_STEPS+1];
    logic signed [ANG_W-1:0] a_reg [CORDIC_STEPS+1];
    logic                    z_reg [CORDIC_STEPS+1];

    always_comb
    begin
        ax  = x_in[CIN_W-1] ? CIN_W'(-x_in) : CIN_W'(x_in);
        ay  = y_in[CIN_W-1] ? CIN_W'(-y_in) : CIN_W'(y_in);
        mx  = (ax > ay) ? ax : ay;
        msb = '0;
        for (int i = 0; i < CIN_W; i++)
        begin
            if (mx[i])
                msb = SH_W'(i);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ny_reg   <= y_in;
            nx_reg   <= x_in;
            sh_reg   <= SH_W'(NORM_TOP) - msb;
            zero_reg <= (mx == '0);
        end
    end

    // scale so the larger magnitude lands in [2^29, 2^30), then fold into the right half plane
    always_comb
    begin
        xs = CX_W'(nx_reg) <<< sh_reg;
        ys = CX_W'(ny_reg) <<< sh_reg;
        if (xs < 0)
        begin
            if (ys >= 0)
            begin
                x0_next = ys;
                y0_next = -xs;
                a0_next = Q30_HALF_PI;
            end
            else
            begin
                x0_next = -ys;
                y0_next = xs;
                a0_next = -Q30_HALF_PI;
            end
        end
        else
        begin
            x0_next = xs;
            y0_next = ys;
            a0_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= x0_next;
            y_reg[0] <= y0_next;
            a_reg[0] <= a0_next;
            z_reg[0] <= zero_reg;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    a_reg[i+1] <= a_reg[i] + ATAN_TAB[i];
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    a_reg[i+1] <= a_reg[i] - ATAN_TAB[i];
                end
                z_reg[i+1] <= z_reg[i];
            end
        end
    end

    assign angle = z_reg[CORDIC_STEPS] ? '0 : a_reg[CORDIC_STEPS];

endmodule

### rtl/core/dik_arm.sv
// one arm of the delta solver: frame rotation, k by pipelined division, root by
// pipelined square root, two atan2 units and candidate selection; depends on dik_pkg, dik_cordic
module dik_arm #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              en,
    input  dik_pkg::dik_cfg_t                 cfg,
    input  logic signed [dik_pkg::COEF_W-1:0] rot_cos,
    input  logic signed [dik_pkg::COEF_W-1:0] rot_sin,
    input  logic signed [dik_pkg::IN_W-1:0]   px,
    input  logic signed [dik_pkg::IN_W-1:0]   py,
    input  logic signed [dik_pkg::IN_W-1:0]   pz,
    output logic signed [dik_pkg::IN_W-1:0]   angle,
    output logic                              bad
);
    import dik_pkg::*;

    localparam int RND_SH = 30 - FRAC_BITS;
    localparam int RW     = PROD_W - 29;

    // stage 1: products
    logic signed [PROD_W-1:0] xc_reg, ys_reg, xs_reg, yc_reg;
    logic signed [IN_W-1:0]   pz1_reg;
    // stage 2: rounded arm frame point
    logic signed [PROD_W:0]   sx, sy;
    logic [PROD_W:0]          mxa, mya;
    logic [RW-1:0]            rx, ry;
    logic signed [XO_W-1:0]   xo_next, yo_next;
    logic signed [XO_W-1:0]   xo2_reg, yo2_reg;
    logic signed [IN_W-1:0]   pz2_reg;
    // stage 3: squares
    logic [SQ_W-1:0]          xsq_reg, ysq_reg, zsq_reg, l1sq_reg, l2sq_reg;
    logic signed [XO_W-1:0]   xo3_reg;
    logic signed [IN_W-1:0]   pz3_reg;
    // stage 4: numerator and radius
    logic signed [NUM_W-1:0]  num_reg;
    logic [SQ_W-1:0]          r2_4_reg;
    logic signed [XO_W-1:0]   xo4_reg;
    logic signed [IN_W-1:0]   pz4_reg;
    // division line, entry 0 is stage 5
    logic [SQ_W-1:0]          mag;
    logic [SQ_W-1:0]          nn_next;
    logic [REG_W:0]           dvs;
    logic [SQ_W-1:0]          rem_reg [DIV_STEPS+1];
    logic [Q_W-1:0]           q_reg   [DIV_STEPS+1];
    logic                     neg_reg [DIV_STEPS+1];
    logic                     ovf_reg [DIV_STEPS+1];
    logic [SQ_W-1:0]          r2d_reg [DIV_STEPS+1];
    logic signed [XO_W-1:0]   xod_reg [DIV_STEPS+1];
    logic signed [IN_W-1:0]   pzd_reg [DIV_STEPS+1];
    // k and its square
    logic [SQ_W-1:0]          qsq_reg;
    logic signed [K_W-1:0]    k1_reg;
    logic [SQ_W-1:0]          r2k_reg;
    logic                     ovfk_reg;
    logic signed [XO_W-1:0]   xok_reg;
    logic signed [IN_W-1:0]   pzk_reg;
    // square root line, entry 0 holds the radicand
    logic [SQ_W-1:0]          sv_reg  [SQRT_STEPS+1];
    logic [SQ_W:0]            sr_reg  [SQRT_STEPS+1];
    logic signed [K_W-1:0]    ks_reg  [SQRT_STEPS+1];
    logic signed [XO_W-1:0]   xos_reg [SQRT_STEPS+1];
    logic signed [IN_W-1:0]   pzs_reg [SQRT_STEPS+1];
    logic                     bs_reg  [SQRT_STEPS+1];
    // angles
    logic signed [CIN_W-1:0]  cs_y, cs_x, ca_y, ca_x;
    logic signed [ANG_W-1:0]  ang_s, ang_a;
    logic                     bc_reg  [CORDIC_LAT];
    logic signed [ANG_W-1:0]  s1, s2, s1w, s2w;
    logic signed [ANG_W-1:0]  s1_reg, s2_reg;
    logic                     bf_reg;
    logic [ANG_W-1:0]         m1, m2, mpick, mrnd;
    logic signed [ANG_W-1:0]  pick, rnd;
    logic signed [IN_W-1:0]   angle_reg;
    logic                     bad_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xc_reg  <= px * rot_cos;
            ys_reg  <= py * rot_sin;
            xs_reg  <= px * rot_sin;
            yc_reg  <= py * rot_cos;
            pz1_reg <= pz;
        end
    end

    // round half away from zero out of Q30
    always_comb
    begin
        sx      = (PROD_W+1)'(xc_reg) + (PROD_W+1)'(ys_reg);
        sy      = (PROD_W+1)'(yc_reg) - (PROD_W+1)'(xs_reg);
        mxa     = sx[PROD_W] ? (PROD_W+1)'(-sx) : (PROD_W+1)'(sx);
        mya     = sy[PROD_W] ? (PROD_W+1)'(-sy) : (PROD_W+1)'(sy);
        rx      = RW'((mxa + ((PROD_W+1)'(1) << 29)) >> 30);
        ry      = RW'((mya + ((PROD_W+1)'(1) << 29)) >> 30);
        xo_next = (sx[PROD_W] ? -signed'(XO_W'(rx)) : signed'(XO_W'(rx))) + XO_W'(cfg.off);
        yo_next = sy[PROD_W] ? -signed'(XO_W'(ry)) : signed'(XO_W'(ry));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xo2_reg  <= xo_next;
            yo2_reg  <= yo_next;
            pz2_reg  <= pz1_reg;

            xsq_reg  <= SQ_W'(xo2_reg) * SQ_W'(xo2_reg);
            ysq_reg  <= SQ_W'(yo2_reg) * SQ_W'(yo2_reg);
            zsq_reg  <= SQ_W'(pz2_reg) * SQ_W'(pz2_reg);
            l1sq_reg <= SQ_W'(cfg.l1) * SQ_W'(cfg.l1);
            l2sq_reg <= SQ_W'(cfg.l2) * SQ_W'(cfg.l2);
            xo3_reg  <= xo2_reg;
            pz3_reg  <= pz2_reg;

            num_reg  <= $signed({1'b0, l2sq_reg}) - $signed({1'b0, l1sq_reg})
                        - $signed({1'b0, SQ_W'(xsq_reg + ysq_reg + zsq_reg)});
            r2_4_reg <= xsq_reg + zsq_reg;
            xo4_reg  <= xo3_reg;
            pz4_reg  <= pz3_reg;
        end
    end

    // k = floor((|num| + l1) / (2 l1)); k of 2^21 or more marks the point unreachable
    always_comb
    begin
        mag     = num_reg[NUM_W-1] ? SQ_W'(-num_reg) : SQ_W'(num_reg);
        nn_next = mag + SQ_W'(cfg.l1);
        dvs     = {cfg.l1, 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= nn_next;
            q_reg[0]   <= '0;
            neg_reg[0] <= (num_reg > 0);
            ovf_reg[0] <= (cfg.l1 == '0) || (nn_next >= (SQ_W'(dvs) << DIV_STEPS));
            r2d_reg[0] <= r2_4_reg;
            xod_reg[0] <= xo4_reg;
            pzd_reg[0] <= pz4_reg;
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                if (rem_reg[i] >= (SQ_W'(dvs) << (DIV_STEPS - 1 - i)))
                begin
                    rem_reg[i+1] <= rem_reg[i] - (SQ_W'(dvs) << (DIV_STEPS - 1 - i));
                    q_reg[i+1]   <= q_reg[i] | (Q_W'(1) << (DIV_STEPS - 1 - i));
                end
                else
                begin
                    rem_reg[i+1] <= rem_reg[i];
                    q_reg[i+1]   <= q_reg[i];
                end
                neg_reg[i+1] <= neg_reg[i];
                ovf_reg[i+1] <= ovf_reg[i];
                r2d_reg[i+1] <= r2d_reg[i];
                xod_reg[i+1] <= xod_reg[i];
                pzd_reg[i+1] <= pzd_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qsq_reg  <= SQ_W'(q_reg[DIV_STEPS]) * SQ_W'(q_reg[DIV_STEPS]);
            k1_reg   <= neg_reg[DIV_STEPS] ? -signed'(K_W'(q_reg[DIV_STEPS]))
                                           : signed'(K_W'(q_reg[DIV_STEPS]));
            r2k_reg  <= r2d_reg[DIV_STEPS];
            ovfk_reg <= ovf_reg[DIV_STEPS];
            xok_reg  <= xod_reg[DIV_STEPS];
            pzk_reg  <= pzd_reg[DIV_STEPS];

            sv_reg[0]  <= r2k_reg - qsq_reg;
            sr_reg[0]  <= '0;
            ks_reg[0]  <= k1_reg;
            xos_reg[0] <= xok_reg;
            pzs_reg[0] <= pzk_reg;
            bs_reg[0]  <= ovfk_reg || (qsq_reg > r2k_reg);
            // floor square root, one result bit per stage
            for (int i = 0; i < SQRT_STEPS; i++)
            begin
                if ({1'b0, sv_reg[i]} >= sr_reg[i] + ((SQ_W+1)'(1) << (2*(SQRT_STEPS-1-i))))
                begin
                    sv_reg[i+1] <= SQ_W'({1'b0, sv_reg[i]} - sr_reg[i]
                                   - ((SQ_W+1)'(1) << (2*(SQRT_STEPS-1-i))));
                    sr_reg[i+1] <= (sr_reg[i] >> 1) + ((SQ_W+1)'(1) << (2*(SQRT_STEPS-1-i)));
                end
                else
                begin
                    sv_reg[i+1] <= sv_reg[i];
                    sr_reg[i+1] <= sr_reg[i] >> 1;
                end
                ks_reg[i+1]  <= ks_reg[i];
                xos_reg[i+1] <= xos_reg[i];
                pzs_reg[i+1] <= pzs_reg[i];
                bs_reg[i+1]  <= bs_reg[i];
            end
        end
    end

    assign cs_y = CIN_W'(ks_reg[SQRT_STEPS]);
    assign cs_x = signed'(CIN_W'(sr_reg[SQRT_STEPS][Q_W-1:0]));
    assign ca_y = CIN_W'(xos_reg[SQRT_STEPS]);
    assign ca_x = -CIN_W'(pzs_reg[SQRT_STEPS]);

    dik_cordic u_cordic_s (
        .clk   (clk),
        .en    (en),
        .y_in  (cs_y),
        .x_in  (cs_x),
        .angle (ang_s)
    );

    dik_cordic u_cordic_a (
        .clk   (clk),
        .en    (en),
        .y_in  (ca_y),
        .x_in  (ca_x),
        .angle (ang_a)
    );

    always_comb
    begin
        s1  = ang_s - ang_a;
        s2  = Q30_PI - ang_s - ang_a;
        s1w = s1;
        if (s1w < -Q30_PI)
            s1w = s1w + Q30_TWO_PI;
        if (s1w > Q30_PI)
            s1w = s1w - Q30_TWO_PI;
        s2w = s2;
        if (s2w < -Q30_PI)
            s2w = s2w + Q30_TWO_PI;
        if (s2w > Q30_PI)
            s2w = s2w - Q30_TWO_PI;
    end

    // ties go to the second candidate
    always_comb
    begin
        m1    = s1_reg[ANG_W-1] ? ANG_W'(-s1_reg) : ANG_W'(s1_reg);
        m2    = s2_reg[ANG_W-1] ? ANG_W'(-s2_reg) : ANG_W'(s2_reg);
        pick  = (m1 < m2) ? s1_reg : s2_reg;
        mpick = (m1 < m2) ? m1 : m2;
        mrnd  = (mpick + (ANG_W'(1) << (RND_SH - 1))) >> RND_SH;
        rnd   = pick[ANG_W-1] ? -signed'(mrnd) : signed'(mrnd);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bc_reg[0] <= bs_reg[SQRT_STEPS];
            for (int i = 1; i < CORDIC_LAT; i++)
                bc_reg[i] <= bc_reg[i-1];
            s1_reg    <= s1w;
            s2_reg    <= s2w;
            bf_reg    <= bc_reg[CORDIC_LAT-1];
            angle_reg <= rnd[IN_W-1:0];
            bad_reg   <= bf_reg;
        end
    end

    assign angle = angle_reg;
    assign bad   = bad_reg;

endmodule

### tb/tb_top.sv
// self-checking testbench for delta_inverse_kinematics: bit-exact fixed-point predictor,
// scoreboard class, random idling on both stream sides and a long output hold-off
// depends on dik_pkg and the delta_inverse_kinematics rtl
module tb_top;
    import dik_pkg::*;

    localparam int LIMIT  = 400000;
    localparam int DRAIN  = 120;
    localparam longint PI30 = 64'sd3373259426;
    localparam longint HPI30 = 64'sd1686629713;

    typedef struct {
        logic [IN_W-1:0] ang_a;
        logic [IN_W-1:0] ang_b;
        logic [IN_W-1:0] ang_c;
        logic [IN_W-1:0] tool;
        logic            unreach;
    } ik_result_t;

    class ik_scoreboard;
        longint base_r, eff_r, up_len, low_len;
        ik_result_t pending[$];
        int errors;

        function new();
            base_r = BASE_RADIUS_RST;
            eff_r = EFFECTOR_RADIUS_RST;
            up_len = UPPER_LENGTH_RST;
            low_len = LOWER_LENGTH_RST;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, longint v);
            case (idx)
                CFG_BASE_RADIUS:     base_r = v;
                CFG_EFFECTOR_RADIUS: eff_r = v;
                CFG_UPPER_LENGTH:    up_len = v;
                default:             low_len = v;
            endcase
        endfunction

        function longint rnd_shift(longint v, int n);
            longint mag, r;
            mag = v < 0 ? -v : v;
            r = (mag + (longint'(1) << (n - 1))) >> n;
            return v < 0 ? -r : r;
        endfunction

        function longint flr_shift(longint v, int n);
            if (v >= 0)
                return v >> n;
            return -((-v - 1) >> n) - 1;
        endfunction

        function longint floor_sqrt(longint v);
            longint res, b;
            res = 0;
            b = longint'(1) << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        function longint atan2_q30(longint y, longint x);
            longint ang, m, ax, ay, t, dx, dy;
            int sh;
            ang = 0;
            sh = 0;
            ax = x < 0 ? -x : x;
            ay = y < 0 ? -y : y;
            m = ax > ay ? ax : ay;
            if (m == 0)
                return 0;
            while (m < (longint'(1) << 29))
            begin
                m = m * 2;
                sh++;
            end
            x = x << sh;
            y = y << sh;
            if (x < 0)
            begin
                t = x;
                if (y >= 0)
                begin
                    x = y;
                    y = -t;
                    ang = HPI30;
                end
                else
                begin
                    x = -y;
                    y = t;
                    ang = -HPI30;
                end
            end
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                dx = flr_shift(y, i);
                dy = flr_shift(x, i);
                if (y > 0)
                begin
                    x += dx;
                    y -= dy;
                    ang += longint'(ATAN_TAB[i]);
                end
                else
                begin
                    x -= dx;
                    y += dy;
                    ang -= longint'(ATAN_TAB[i]);
                end
            end
            return ang;
        endfunction

        // returns 0 when the arm cannot reach the point
        function bit arm_angle(int a, longint px, longint py, longint pz, output longint ang);
            longint cs, sn, xo, yo, num, mag, k, r2, k2, c, s, al, s1, s2;
            ang = 0;
            cs = longint'(ROT_COS[a]);
            sn = longint'(ROT_SIN[a]);
            xo = rnd_shift(cs * px + sn * py, 30) + (eff_r - base_r);
            yo = rnd_shift(-sn * px + cs * py, 30);
            if (up_len == 0)
                return 0;
            num = low_len * low_len - up_len * up_len - (xo * xo + yo * yo + pz * pz);
            mag = num < 0 ? -num : num;
            k = (mag + up_len) / (2 * up_len);
            if (k >= (longint'(1) << 21))
                return 0;
            if (num > 0)
                k = -k;
            r2 = xo * xo + pz * pz;
            k2 = k * k;
            if (k2 > r2)
                return 0;
            c = floor_sqrt(r2 - k2);
            s = atan2_q30(k, c);
            al = atan2_q30(xo, -pz);
            s1 = s - al;
            s2 = PI30 - s - al;
            if (s1 < -PI30) s1 += 2 * PI30;
            if (s1 > PI30) s1 -= 2 * PI30;
            if (s2 < -PI30) s2 += 2 * PI30;
            if (s2 > PI30) s2 -= 2 * PI30;
            ang = ((s1 < 0 ? -s1 : s1) < (s2 < 0 ? -s2 : s2)) ? s1 : s2;
            return 1;
        endfunction

        function void note_request(logic [TDATA_W-1:0] d);
            longint p[3], ang[3];
            bit ok;
            ik_result_t r;
            for (int i = 0; i < 3; i++)
                p[i] = longint'($signed(d[i*IN_W +: IN_W]));
            ok = 1;
            for (int a = 0; a < 3; a++)
                if (!arm_angle(a, p[0], p[1], p[2], ang[a]))
                    ok = 0;
            r.ang_a = ok ? IN_W'(rnd_shift(ang[0], 30 - 16)) : '0;
            r.ang_b = ok ? IN_W'(rnd_shift(ang[1], 30 - 16)) : '0;
            r.ang_c = ok ? IN_W'(rnd_shift(ang[2], 30 - 16)) : '0;
            r.tool = d[3*IN_W +: IN_W];
            r.unreach = !ok;
            pending = {pending, r};
        endfunction

        function void check_result(logic [TDATA_W-1:0] d, logic u);
            ik_result_t e;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h / %b", d, u);
                return;
            end
            e = pending.pop_front();
            if (d[0 +: IN_W] !== e.ang_a || d[IN_W +: IN_W] !== e.ang_b ||
                d[2*IN_W +: IN_W] !== e.ang_c || d[3*IN_W +: IN_W] !== e.tool ||
                u !== e.unreach)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch exp a=%h b=%h c=%h t=%h u=%b got a=%h b=%h c=%h t=%h u=%b",
                        e.ang_a, e.ang_b, e.ang_c, e.tool, e.unreach,
                        d[0 +: IN_W], d[IN_W +: IN_W], d[2*IN_W +: IN_W],
                        d[3*IN_W +: IN_W], u);
            end
        endfunction
    endclass

    logic clk, rst_n;
    logic s_tvalid, s_tready, m_tvalid, m_tready;
    logic [TDATA_W-1:0] s_tdata, m_tdata;
    logic [0:0] m_tuser;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [REG_W-1:0] cfg_wdata;

    ik_scoreboard sb;
    int idle_mode;      // 0: sender 37 / receiver 86, 1: swapped, 2: none
    bit hold_req;
    bit hold_done;
    int hold_cnt;
    int cycles;

    delta_inverse_kinematics DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        sb = new();
        idle_mode = 0;
        hold_req = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        m_tready = 0;
        cfg_wr_en = 0;
        cfg_index = CFG_BASE_RADIUS;
        cfg_wdata = '0;
        cycles = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
    end

    // receiver: random stalls plus one long hold-off on request
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser[0]);
        if (hold_req && !hold_done)
        begin
            hold_cnt = 400;
            hold_done = 1;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            m_tready <= 0;
        end
        else if (idle_mode == 0)
            m_tready <= ($urandom_range(0, 99) >= 86);
        else if (idle_mode == 1)
            m_tready <= ($urandom_range(0, 99) >= 37);
        else
            m_tready <= 1;
    end

    task automatic send_point(int px, int py, int pz, int rot);
        int pct;
        pct = idle_mode == 0 ? 37 : (idle_mode == 1 ? 86 : 0);
        while ($urandom_range(0, 99) < pct)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {4'b0, IN_W'(rot), IN_W'(pz), IN_W'(py), IN_W'(px)};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(s_tdata);
    endtask

    task automatic wait_idle();
        s_tvalid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_geometry(int b, int e, int u, int l);
        int v[4];
        v = '{b, e, u, l};
        for (int i = 0; i < 4; i++)
        begin
            cfg_wr_en <= 1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_wdata <= REG_W'(v[i]);
            sb.set_reg(CFG_IDX_W'(i), v[i]);
            @(posedge clk);
        end
        cfg_wr_en <= 0;
        @(posedge clk);
    endtask

    function automatic int rnd_signed(int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    task automatic random_points(int n);
        int reach, span;
        reach = int'(sb.up_len + sb.low_len);
        span = int'(sb.low_len / 2) + 1;
        if (reach > 131072) reach = 131072;
        if (span > 131072) span = 131072;
        for (int i = 0; i < n; i++)
        begin
            // mostly points inside the work envelope, the rest anywhere
            if ($urandom_range(0, 3) != 0)
                send_point(rnd_signed(span), rnd_signed(span), -int'($urandom_range(0, reach)),
                    rnd_signed(205887));
            else
                send_point(rnd_signed(131072), rnd_signed(131072), rnd_signed(131072),
                    rnd_signed(205887));
        end
    endtask

    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        // reset geometry, directed points
        send_point(0, 0, -19660, 0);
        send_point(0, 0, -26000, 205887);
        send_point(0, 0, -26000, -205887);
        send_point(6000, -4000, -22000, 1000);
        send_point(131072, 131072, 131072, -1);
        send_point(-131072, -131072, -131072, 1);
        send_point(131072, -131072, -131072, 0);
        send_point(-131072, 131072, 0, 0);
        send_point(0, 0, 0, 0);
        send_point(0, 0, 131072, 0);
        send_point(0, 0, -131072, 0);
        random_points(60);
        wait_idle();

        // widest spread; equal links make an arm-frame origin point degenerate
        write_geometry(0, 131072, 131072, 131072);
        send_point(-131072, 0, 0, 0);
        send_point(0, 0, -131072, 0);
        hold_req = 1;
        random_points(80);
        hold_req = 0;
        wait_idle();

        // tiny upper link: k grows huge
        write_geometry(131072, 0, 1, 131072);
        send_point(0, 0, -1, 0);
        random_points(40);
        wait_idle();

        idle_mode = 1;
        // zero upper link
        write_geometry(0, 0, 0, 1);
        random_points(20);
        wait_idle();

        write_geometry(13107, 6554, 19660, 45875);
        random_points(110);
        wait_idle();

        idle_mode = 2;
        write_geometry(6554, 3277, 13107, 26214);
        random_points(110);
        wait_idle();

        write_geometry(int'($urandom_range(0, 131072)), int'($urandom_range(0, 131072)),
            int'($urandom_range(1, 131072)), int'($urandom_range(1, 131072)));
        random_points(110);
        wait_idle();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule

### sim.f
rtl/core/dik_pkg.sv
rtl/core/dik_cordic.sv
rtl/core/dik_arm.sv
rtl/core/delta_inverse_kinematics.sv
tb/tb_top.sv
